/* rtl/spsq_pkg.sv */
// Package for the stepper position sequencer: widths, item types, register codes, coil tables.
package spsq_pkg;

	// Width of the internal position and goal registers (8 to 32).
	localparam int unsigned POSITION_WIDTH = 16;
	// Field widths fixed by the item formats.
	localparam int unsigned FIELD_WIDTH    = 16;
	localparam int unsigned INTERVAL_WIDTH = 8;
	localparam int unsigned COIL_WIDTH     = 4;
	localparam int unsigned CFG_IDX_WIDTH  = 2;
	localparam int unsigned CFG_DATA_WIDTH = 16;
	// Width at which the target is clamped against the limit register.
	localparam int unsigned CLAMP_WIDTH =
		(POSITION_WIDTH > FIELD_WIDTH) ? POSITION_WIDTH : FIELD_WIDTH;

	localparam logic [FIELD_WIDTH-1:0]    MAX_POSITION_RST  = 16'd4095;
	localparam logic [INTERVAL_WIDTH-1:0] STEP_INTERVAL_RST = 8'd2;
	localparam logic                      HALF_STEP_RST     = 1'b1;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		CFG_HALF_STEP_MODE = 2'd0,
		CFG_MAX_POSITION   = 2'd1,
		CFG_STEP_INTERVAL  = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		CMD_MOVE = 1'b0,
		CMD_TICK = 1'b1
	} cmd_code_t;

	typedef struct packed {
		logic                   cmd;
		logic [FIELD_WIDTH-1:0] target_position;
	} cmd_item_t;

	typedef struct packed {
		logic [COIL_WIDTH-1:0]  coil_pattern;
		logic [FIELD_WIDTH-1:0] current_position;
		logic                   busy_res;
	} res_item_t;

	typedef logic [COIL_WIDTH-1:0] coil_t;

	localparam coil_t FULL_TAB [4] = '{4'h3, 4'h6, 4'hC, 4'h9};
	localparam coil_t HALF_TAB [8] = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

	// Coil pattern for a step that uses the given phase (low three bits).
	function automatic coil_t coil_for(input logic [2:0] phase, input logic half_mode);
		coil_t pat;
		if (half_mode) begin
			pat = HALF_TAB[~phase];
		end else begin
			pat = FULL_TAB[phase[1:0]];
		end
		return pat;
	endfunction

endpackage

/* rtl/stepper_position_sequencer_unit.sv */
// Top level of the four-coil stepper position sequencer.
//
// Usage:
//  - cmd channel (cmd_valid / cmd_stall / cmd_item): each item is either a move to
//    target_position (clamped to max_position) or one time tick.
//  - res channel (res_valid / res_stall / res_item): exactly one result item per
//    command item, in order: coil pattern, position after the item, busy flag.
//  - cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register writes,
//    always ready; write only while no items are in flight.
// An accepted item sits in the input register, passes the update logic and is
// loaded into the result register when the pipe moves on. Throughput is one
// item per cycle while the receiver does not stall; the state update is a
// single compare, increment or decrement and a table lookup.
// While the receiver stalls with a result waiting, the input register holds and
// cmd_stall is raised once it is full; nothing is dropped or repeated.
// Reset clears position, goal, hold count, busy and coils (all coils off) and
// loads the registers with half step mode, limit 4095 and interval 2.
module stepper_position_sequencer_unit
	import spsq_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	// command items
	input  logic                      cmd_valid,
	output logic                      cmd_stall,
	input  cmd_item_t                 cmd_item,
	// result items
	output logic                      res_valid,
	input  logic                      res_stall,
	output res_item_t                 res_item,
	// configuration writes
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

	typedef logic [POSITION_WIDTH-1:0] pos_t;

	// configuration registers
	logic                      half_mode_q;
	logic [FIELD_WIDTH-1:0]    max_pos_q;
	logic [INTERVAL_WIDTH-1:0] interval_q;

	// sequencer state
	pos_t                      pos_q;
	pos_t                      goal_q;
	logic [INTERVAL_WIDTH-1:0] hold_q;
	logic                      moving_q;
	coil_t                     coils_q;

	// input stage
	logic      item_valid_s1;
	cmd_item_t item_s1;

	// result register
	logic      res_valid_q;
	res_item_t res_q;

	logic advance;
	logic take_item;

	// next state
	pos_t                      pos_d;
	pos_t                      goal_d;
	logic [INTERVAL_WIDTH-1:0] hold_d;
	logic                      moving_d;
	coil_t                     coils_d;

	// helpers
	logic [CLAMP_WIDTH-1:0]    tgt_w;
	logic [CLAMP_WIDTH-1:0]    max_w;
	pos_t                      goal_new;
	pos_t                      goal_eff;
	logic [INTERVAL_WIDTH-1:0] hold_dec;
	logic [INTERVAL_WIDTH-1:0] hold_load;
	logic                      do_step;
	logic                      do_halt;
	logic                      step_up;
	pos_t                      pos_dn;
	logic [2:0]                phase;

	// ---- handshakes ----
	// The pipe moves on whenever the result register is free or being emptied.
	assign advance   = !res_valid_q || !res_stall;
	assign cmd_stall = item_valid_s1 && !advance;
	assign take_item = item_valid_s1 && advance;
	assign res_valid = res_valid_q;
	assign res_item  = res_q;
	assign cfg_ready = 1'b1;

	// ---- configuration ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_mode_q <= HALF_STEP_RST;
			max_pos_q   <= MAX_POSITION_RST;
			interval_q  <= STEP_INTERVAL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_HALF_STEP_MODE: half_mode_q <= cfg_data[0];
				CFG_MAX_POSITION:   max_pos_q   <= cfg_data[FIELD_WIDTH-1:0];
				CFG_STEP_INTERVAL:  interval_q  <= cfg_data[INTERVAL_WIDTH-1:0];
				default: ; // unused index, write is dropped
			endcase
		end
	end

	// ---- input register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			item_valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			item_s1 <= cmd_item;
		end
	end

	// ---- update logic ----
	// Target is first cut to the position width, then clamped to the limit.
	assign tgt_w    = CLAMP_WIDTH'(pos_t'(item_s1.target_position));
	assign max_w    = CLAMP_WIDTH'(max_pos_q);
	assign goal_new = (tgt_w > max_w) ? pos_t'(max_w) : pos_t'(tgt_w);

	assign hold_dec  = (hold_q == '0) ? '0 : hold_q - 1'b1;
	// a zero interval is held as one tick
	assign hold_load = (interval_q == '0) ? INTERVAL_WIDTH'(1) : interval_q;

	always_comb begin
		goal_eff = goal_q;
		do_step  = 1'b0;
		do_halt  = 1'b0;
		hold_d   = hold_q;
		case (cmd_code_t'(item_s1.cmd))
			CMD_MOVE: begin
				goal_eff = goal_new;
				if (goal_new == pos_q) begin
					do_halt = 1'b1;
				end else if (!moving_q) begin
					do_step = 1'b1;
				end
			end
			CMD_TICK: begin
				if (moving_q) begin
					hold_d = hold_dec;
					if (hold_dec == '0) begin
						if (pos_q == goal_q) begin
							do_halt = 1'b1;
						end else begin
							do_step = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
	end

	// Step between p and p+1 uses phase p, whichever way it goes.
	assign step_up = goal_eff > pos_q;
	assign pos_dn  = pos_q - 1'b1;
	assign phase   = step_up ? pos_q[2:0] : pos_dn[2:0];

	always_comb begin
		goal_d   = goal_eff;
		pos_d    = pos_q;
		moving_d = moving_q;
		coils_d  = coils_q;
		if (do_halt) begin
			coils_d  = '0;
			moving_d = 1'b0;
		end else if (do_step) begin
			pos_d    = step_up ? pos_q + 1'b1 : pos_dn;
			coils_d  = coil_for(phase, half_mode_q);
			moving_d = 1'b1;
		end
	end

	// hold count is split out so each branch reads cleanly
	logic [INTERVAL_WIDTH-1:0] hold_n;
	always_comb begin
		if (do_halt) begin
			hold_n = '0;
		end else if (do_step) begin
			hold_n = hold_load;
		end else begin
			hold_n = hold_d;
		end
	end

	// ---- state and result registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			goal_q   <= '0;
			hold_q   <= '0;
			moving_q <= 1'b0;
			coils_q  <= '0;
		end else if (take_item) begin
			pos_q    <= pos_d;
			goal_q   <= goal_d;
			hold_q   <= hold_n;
			moving_q <= moving_d;
			coils_q  <= coils_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= item_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_item) begin
			res_q.coil_pattern     <= coils_d;
			res_q.current_position <= FIELD_WIDTH'(pos_d);
			res_q.busy_res         <= moving_d;
		end
	end

endmodule
